[design/running_average_background_subtract_assert.svh]
// Assertion macros shared by the background-subtract RTL.
// Both expand to nothing when SYNTH is defined; each needs clk and rst in scope.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define RABS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
// Check that cons holds on the cycle after ante.
`define RABS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define RABS_ASSERT(lbl, prop)
`define RABS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/rabs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the running-average background subtractor.
// No dependencies.
package rabs_pkg;

  localparam int PIX_IDX_W = 19;
  localparam int CH_W      = 8;
  localparam int ALPHA_W   = 16;
  localparam int THR_W     = 18;
  localparam int NUM_LANES = 3;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_SUBTRACT = 1'b1;

  localparam logic CFG_ALPHA     = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd655;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 18'd900;

  // Half of one unit of the 0.16 alpha fraction, for round-half-up.
  localparam int BLEND_ROUND = 32768;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Control that travels alongside the per-lane data.
  typedef struct packed {
    logic                 valid;
    logic                 op;
    logic [PIX_IDX_W-1:0] idx;
  } rabs_tag_t;

  typedef struct packed {
    logic                 foreground;
    logic [PIX_IDX_W-1:0] out_index;
  } rabs_result_t;

endpackage

[design/running_average_background_subtract.sv]
`timescale 1ns / 1ps
// Running-average RGB background subtraction with a per-pixel model memory.
// Throughput: one pixel per cycle while s_tready allows it (the output queue
// has room for every word in flight), set by the model memory taking one read
// and one write per cycle, the previous write forwarded on an index match.
// Reset clears the pipeline, the output queue and restores alpha and threshold;
// the model memory is not cleared and must be loaded before it is subtracted.
`include "running_average_background_subtract_assert.svh"
module running_average_background_subtract import rabs_pkg::*; #(
  parameter int MAX_PIXELS = 524288,
  parameter int FRAC_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [THR_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [47:0]      s_tdata,  // pixel_index[18:0], red, green, blue, zero pad
  input  logic [0:0]       s_tuser,  // op
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata   // foreground, out_index[18:0], zero pad
);

  localparam int MW      = CH_W + FRAC_BITS;
  localparam int IDX_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int MAX_W   = $clog2(MAX_PIXELS + 1);
  localparam int SH      = PIX_IDX_W + IDX_W;
  localparam int RECIP_W = PIX_IDX_W + 2;
  localparam int PROD_W  = PIX_IDX_W + RECIP_W;
  localparam int RED_W   = PIX_IDX_W + MAX_W;
  localparam longint unsigned RECIP = (64'd1 << SH) / 64'(MAX_PIXELS);
  localparam int INF_W   = 3;

  logic [ALPHA_W-1:0] alpha;
  logic [THR_W-1:0]   threshold;

  logic                   accept;
  logic                   a_valid, b_valid, c_valid, s1_valid, s2_valid, s3_valid;
  logic                   a_op, b_op, c_op, s1_op, s2_op, s3_op;
  logic [PIX_IDX_W-1:0]   a_idx, b_idx, c_idx, s1_idx, s2_idx, s3_idx;
  logic [NUM_LANES*CH_W-1:0] a_pix, b_pix, c_pix, s1_pix;
  logic [PIX_IDX_W-1:0]   b_q, c_qm;
  logic [PROD_W-1:0]      a_prod;
  logic [RED_W-1:0]       b_qm_full;
  logic [RED_W-1:0]       c_diff, c_rem;
  logic [IDX_W-1:0]       rd_addr, s1_addr;

  logic [NUM_LANES*MW-1:0] model_mem [MAX_PIXELS];
  logic [NUM_LANES*MW-1:0] model_rd;
  logic [NUM_LANES*MW-1:0] new_word;
  logic                    fwd_valid;
  logic [IDX_W-1:0]        fwd_addr;
  logic [NUM_LANES*MW-1:0] fwd_word;
  logic                    fwd_hit;

  logic [2*MW-1:0] lane_sq [NUM_LANES];
  rabs_tag_t       s3_tag;
  logic            res_valid;
  rabs_result_t    res;
  rabs_result_t    head;
  logic            fifo_pop;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [INF_W-1:0]      inflight;
  logic [FIFO_CNT_W:0]   occupancy;

  // Config writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:     alpha     <= cfg_data[ALPHA_W-1:0];
        CFG_THRESHOLD: threshold <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Admit a word only when the queue has room for everything in flight.
  always_comb begin
    inflight = INF_W'(a_valid) + INF_W'(b_valid) + INF_W'(c_valid) + INF_W'(s1_valid)
             + INF_W'(s2_valid) + INF_W'(s3_valid) + INF_W'(res_valid);
    occupancy = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(inflight);
  end
  assign s_tready = !rst && (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;

  // Index wrap: estimate quotient by reciprocal, then one correcting subtract.
  always_comb begin
    a_prod    = PROD_W'(a_idx) * PROD_W'(RECIP_W'(RECIP));
    b_qm_full = RED_W'(b_q) * RED_W'(MAX_PIXELS);
    c_diff    = RED_W'(c_idx) - RED_W'(c_qm);
    c_rem     = (c_diff >= RED_W'(MAX_PIXELS)) ? (c_diff - RED_W'(MAX_PIXELS)) : c_diff;
    rd_addr   = c_rem[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      a_valid  <= accept;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      s1_valid <= c_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    a_op   <= s_tuser[0];
    a_idx  <= s_tdata[PIX_IDX_W-1:0];
    a_pix  <= s_tdata[PIX_IDX_W +: NUM_LANES*CH_W];
    b_op   <= a_op;
    b_idx  <= a_idx;
    b_pix  <= a_pix;
    b_q    <= PIX_IDX_W'(a_prod >> SH);
    c_op   <= b_op;
    c_idx  <= b_idx;
    c_pix  <= b_pix;
    c_qm   <= b_qm_full[PIX_IDX_W-1:0];
    s1_op  <= c_op;
    s1_idx <= c_idx;
    s1_pix <= c_pix;
    s1_addr <= rd_addr;
    s2_op  <= s1_op;
    s2_idx <= s1_idx;
    s3_op  <= s2_op;
    s3_idx <= s2_idx;
  end

  // Model memory: read ahead of stage 1, write back from stage 1.
  always_ff @(posedge clk) begin
    model_rd <= model_mem[rd_addr];
    if (s1_valid) begin
      model_mem[s1_addr] <= new_word;
    end
  end

  // Hold the last write; the read issued on the same edge missed it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_valid) begin
      fwd_valid <= 1'b1;
    end
    if (s1_valid) begin
      fwd_addr <= s1_addr;
      fwd_word <= new_word;
    end
  end

  assign fwd_hit = fwd_valid && (fwd_addr == s1_addr);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rabs_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .op        (s1_op),
      .fwd_hit   (fwd_hit),
      .pix       (s1_pix[g*CH_W +: CH_W]),
      .rd_model  (model_rd[g*MW +: MW]),
      .fwd_model (fwd_word[g*MW +: MW]),
      .alpha     (alpha),
      .new_model (new_word[g*MW +: MW]),
      .sq        (lane_sq[g])
    );
  end

  assign s3_tag = '{valid: s3_valid, op: s3_op, idx: s3_idx};

  rabs_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .tag       (s3_tag),
    .sq        (lane_sq),
    .threshold (threshold),
    .res_valid (res_valid),
    .res       (res)
  );

  assign fifo_pop = m_tvalid && m_tready;

  rabs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (fifo_pop),
    .head      (head),
    .not_empty (m_tvalid),
    .count     (fifo_count)
  );

  assign m_tdata = {{(24 - PIX_IDX_W - 1){1'b0}}, head.out_index, head.foreground};

  `RABS_ASSERT(a_credit, occupancy <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
  `RABS_ASSERT_NEXT(a_fwd_track, s1_valid, fwd_valid && fwd_addr == $past(s1_addr))

endmodule

[design/rabs_lane.sv]
`timescale 1ns / 1ps
// One color channel: model blend for write-back and squared difference.
// Depends on rabs_pkg.
module rabs_lane import rabs_pkg::*; #(
  parameter int FRAC_BITS = 8,
  localparam int MW = CH_W + FRAC_BITS
) (
  input  logic               clk,
  input  logic               op,
  input  logic               fwd_hit,
  input  logic [CH_W-1:0]    pix,
  input  logic [MW-1:0]      rd_model,
  input  logic [MW-1:0]      fwd_model,
  input  logic [ALPHA_W-1:0] alpha,
  output logic [MW-1:0]      new_model,
  output logic [2*MW-1:0]    sq
);

  localparam int ACC_W = MW + ALPHA_W + 2;

  logic [MW-1:0]      model;
  logic [MW-1:0]      p_fix;
  logic [MW-1:0]      mag;
  logic [MW-1:0]      mag_q;
  logic [ALPHA_W:0]   beta;
  logic [ACC_W-1:0]   acc;
  logic [2*MW-1:0]    sq_full;

  always_comb begin
    model = fwd_hit ? fwd_model : rd_model;
    p_fix = MW'(pix) << FRAC_BITS;
    mag   = (p_fix >= model) ? (p_fix - model) : (model - p_fix);
    beta  = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, alpha};
    acc   = ACC_W'(alpha) * ACC_W'(p_fix) + ACC_W'(beta) * ACC_W'(model)
          + ACC_W'(BLEND_ROUND);
    new_model = (op == OP_LOAD) ? p_fix : acc[ALPHA_W +: MW];
    sq_full   = (2*MW)'(mag_q) * (2*MW)'(mag_q);
  end

  always_ff @(posedge clk) begin
    mag_q <= mag;
    sq    <= sq_full;
  end

endmodule

[design/rabs_merge.sv]
`timescale 1ns / 1ps
// Sums the lane squares and, for subtract words, compares against the scaled threshold.
// Depends on rabs_pkg.
`include "running_average_background_subtract_assert.svh"
module rabs_merge import rabs_pkg::*; #(
  parameter int FRAC_BITS = 8,
  localparam int MW = CH_W + FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  rabs_tag_t       tag,
  input  logic [2*MW-1:0] sq [NUM_LANES],
  input  logic [THR_W-1:0] threshold,
  output logic            res_valid,
  output rabs_result_t    res
);

  localparam int SUM_W = 2 * MW + 2;

  logic [SUM_W-1:0] sq_sum;
  logic [SUM_W-1:0] limit;

  always_comb begin
    sq_sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sq_sum = sq_sum + SUM_W'(sq[i]);
    end
    limit = SUM_W'(threshold) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= tag.valid;
    end
    res.out_index  <= tag.idx;
    res.foreground <= (tag.op == OP_SUBTRACT) && (sq_sum > limit);
  end

  `RABS_ASSERT_NEXT(a_load_background, tag.valid && tag.op == OP_LOAD, !res.foreground)

endmodule

[design/rabs_fifo.sv]
`timescale 1ns / 1ps
// Output queue for result words, decoupling the pipeline from m_tready.
// Depends on rabs_pkg.
`include "running_average_background_subtract_assert.svh"
module rabs_fifo import rabs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rabs_result_t          push_data,
  input  logic                  pop,
  output rabs_result_t          head,
  output logic                  not_empty,
  output logic [FIFO_CNT_W-1:0] count
);

  rabs_result_t            slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `RABS_ASSERT(a_no_overflow, !push || pop || count < FIFO_CNT_W'(FIFO_DEPTH))
  `RABS_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)

endmodule

[tb/tb_running_average_background_subtract.sv]
`timescale 1ns / 1ps
// Self-checking bench for running_average_background_subtract: streams RGB pixel words,
// predicts each foreground mask bit and its model update, and checks every output word.
// Depends on rabs_pkg and the block's RTL.
module tb_running_average_background_subtract import rabs_pkg::*;;

  localparam int FRAC = 8;
  localparam int LONG_STALL = 300;

  typedef struct packed {
    logic                 op;
    logic [PIX_IDX_W-1:0] idx;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
  } pixel_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_ALPHA;
  logic [THR_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [47:0]      s_tdata = '0;   // pixel_index[18:0], red, green, blue, zero pad
  logic [0:0]       s_tuser = '0;   // op
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [23:0]      m_tdata;        // foreground, out_index[18:0], zero pad

  // Predictor state: background model in 8.8 per channel, plus register copies
  logic [2:0][15:0]     bg_model [logic [PIX_IDX_W-1:0]];
  logic [ALPHA_W-1:0]   alpha_q = ALPHA_RESET;
  logic [THR_W-1:0]     thresh_q = THRESHOLD_RESET;

  pixel_item_t  pixel_queue [$];
  rabs_result_t mask_queue [$];
  pixel_item_t  cur_pixel;

  // Stimulus-side bookkeeping: which entries hold a model, and the last pixel loaded there
  logic [2:0][7:0]      gen_base [logic [PIX_IDX_W-1:0]];
  logic [PIX_IDX_W-1:0] loaded_idx [$];
  logic [PIX_IDX_W-1:0] last_idx;

  int          send_gap;
  int          take_gap;
  int          stall_left;
  logic        stall_kick = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned mismatch_count;
  int unsigned words_in, words_out, fg_seen, load_count, sub_count, reg_writes;
  rabs_result_t got_mask, exp_mask;

  running_average_background_subtract uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d mask words outstanding", mask_queue.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Work out the mask bit for one pixel and blend its model entry
  function automatic rabs_result_t predict_mask(pixel_item_t px);
    logic [2:0][7:0]  chan;
    logic [2:0][15:0] cur, upd;
    logic [15:0]      p_fix, mag;
    logic [63:0]      sq_sum, acc;
    rabs_result_t     res;
    chan = {px.blue, px.green, px.red};
    cur = bg_model.exists(px.idx) ? bg_model[px.idx] : '0;
    sq_sum = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      p_fix = {chan[c], 8'h00};
      mag = (p_fix >= cur[c]) ? p_fix - cur[c] : cur[c] - p_fix;
      sq_sum += 64'(mag) * 64'(mag);
      acc = 64'(alpha_q) * 64'(p_fix) + (64'd65536 - 64'(alpha_q)) * 64'(cur[c])
            + 64'(BLEND_ROUND);
      upd[c] = (px.op == OP_LOAD) ? p_fix : acc[31:16];
    end
    bg_model[px.idx] = upd;
    res.out_index = px.idx;
    res.foreground = (px.op == OP_SUBTRACT) && (sq_sum > (64'(thresh_q) << (2 * FRAC)));
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 20)) - 10;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic queue_pixel(input logic op, input logic [PIX_IDX_W-1:0] idx,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_item_t px;
    px = '{op: op, idx: idx, red: r, green: g, blue: b};
    pixel_queue.push_back(px);
    if (op == OP_LOAD) begin
      if (!gen_base.exists(idx)) loaded_idx.push_back(idx);
      gen_base[idx] = {b, g, r};
      load_count++;
    end else begin
      sub_count++;
    end
    last_idx = idx;
  endtask

  // Mostly subtracts on loaded entries, with some loads and hot indices for hazards
  task automatic queue_random(input int count);
    int roll, pick;
    logic [PIX_IDX_W-1:0] idx;
    logic [2:0][7:0] base;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (loaded_idx.size() == 0 || roll < 22) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) idx = 19'($urandom_range(0, 15));
        else if (pick == 1) idx = 19'h7FFFF - 19'($urandom_range(0, 15));
        else idx = 19'($urandom);
        queue_pixel(OP_LOAD, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 40) idx = last_idx;
        else idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
        base = gen_base[idx];
        if ($urandom_range(0, 1) == 0)
          queue_pixel(OP_SUBTRACT, idx, jitter(base[0]), jitter(base[1]), jitter(base[2]));
        else
          queue_pixel(OP_SUBTRACT, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic which, input logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_ALPHA) alpha_q = val[ALPHA_W-1:0];
    else thresh_q = val;
    reg_writes++;
  endtask

  // Hold until every queued word has come back out, then let write-back settle
  task automatic drain();
    while (pixel_queue.size() != 0 || s_tvalid || mask_queue.size() != 0 ||
           words_out < load_count + sub_count) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        mask_queue.push_back(predict_mask(cur_pixel));
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          cur_pixel = pixel_queue.pop_front();
          s_tdata <= {5'd0, cur_pixel.blue, cur_pixel.green, cur_pixel.red, cur_pixel.idx};
          s_tuser <= cur_pixel.op;
          s_tvalid <= 1'b1;
          send_gap = (stall_left != 0) ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off
  always @(posedge clk) begin
    if (rst) stall_left <= 0;
    else if (stall_kick) stall_left <= LONG_STALL;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      take_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_out++;
        got_mask.foreground = m_tdata[0];
        got_mask.out_index = m_tdata[19:1];
        if (got_mask.foreground) fg_seen++;
        if (mask_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected mask word fg=%0d idx=%0d", got_mask.foreground,
                     got_mask.out_index);
        end else begin
          exp_mask = mask_queue.pop_front();
          if (got_mask.foreground !== exp_mask.foreground ||
              got_mask.out_index !== exp_mask.out_index) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mask word %0d: expected fg=%0d idx=%0d, got fg=%0d idx=%0d",
                       words_out, exp_mask.foreground, exp_mask.out_index,
                       got_mask.foreground, got_mask.out_index);
          end
        end
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        take_gap = pick_gap();
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: exact threshold edge, channel extremes, index extremes, back-to-back reuse
    queue_pixel(OP_LOAD,     19'd0,       8'd0,   8'd0,   8'd0);
    queue_pixel(OP_SUBTRACT, 19'd0,       8'd30,  8'd0,   8'd0);
    queue_pixel(OP_LOAD,     19'd1,       8'd0,   8'd0,   8'd0);
    queue_pixel(OP_SUBTRACT, 19'd1,       8'd31,  8'd0,   8'd0);
    queue_pixel(OP_LOAD,     19'h7FFFF,   8'd255, 8'd255, 8'd255);
    queue_pixel(OP_SUBTRACT, 19'h7FFFF,   8'd255, 8'd255, 8'd255);
    queue_pixel(OP_SUBTRACT, 19'h7FFFF,   8'd0,   8'd0,   8'd0);
    queue_pixel(OP_LOAD,     19'h55555,   8'hAA,  8'h55,  8'hFF);
    queue_pixel(OP_SUBTRACT, 19'h55555,   8'h55,  8'hAA,  8'h00);
    queue_pixel(OP_LOAD,     19'h2AAAA,   8'd128, 8'd128, 8'd128);
    queue_pixel(OP_SUBTRACT, 19'h2AAAA,   8'd145, 8'd145, 8'd145);
    queue_pixel(OP_SUBTRACT, 19'h2AAAA,   8'd111, 8'd111, 8'd111);
    queue_pixel(OP_LOAD,     19'd2,       8'd200, 8'd10,  8'd90);
    queue_pixel(OP_SUBTRACT, 19'd2,       8'd0,   8'd255, 8'd0);
    queue_pixel(OP_SUBTRACT, 19'd2,       8'd0,   8'd255, 8'd0);
    queue_pixel(OP_SUBTRACT, 19'd2,       8'd200, 8'd10,  8'd90);
    queue_pixel(OP_LOAD,     19'd2,       8'd1,   8'd2,   8'd3);
    queue_pixel(OP_SUBTRACT, 19'd2,       8'd1,   8'd2,   8'd3);
    queue_pixel(OP_LOAD,     19'h40000,   8'd0,   8'd255, 8'd0);
    queue_pixel(OP_SUBTRACT, 19'h40000,   8'd255, 8'd0,   8'd255);
    drain();

    // Alpha zero freezes the model; threshold zero flags any difference
    write_reg(CFG_ALPHA, '0);
    write_reg(CFG_THRESHOLD, '0);
    queue_random(330);
    drain();

    write_reg(CFG_ALPHA, 18'd65535);
    write_reg(CFG_THRESHOLD, 18'd195075);
    no_idle = 1'b1;
    queue_random(280);
    drain();
    no_idle = 1'b0;

    // Fill the block while the output is held off
    write_reg(CFG_ALPHA, 18'd1);
    write_reg(CFG_THRESHOLD, 18'd131071);
    queue_random(300);
    @(posedge clk);
    stall_kick <= 1'b1;
    @(posedge clk);
    stall_kick <= 1'b0;
    drain();

    write_reg(CFG_ALPHA, 18'($urandom_range(0, 65535)));
    write_reg(CFG_THRESHOLD, 18'($urandom_range(0, 195075)));
    queue_random(330);
    drain();

    write_reg(CFG_ALPHA, 18'(ALPHA_RESET));
    write_reg(CFG_THRESHOLD, THRESHOLD_RESET);
    queue_random(300);
    drain();

    if (mask_queue.size() != 0) mismatch_count++;
    $display("Covered %0d pixel words (%0d model loads, %0d subtracts), %0d flagged foreground",
             words_in, load_count, sub_count, fg_seen);
    $display("Across %0d register writes and one %0d-cycle output stall; %0d mismatches",
             reg_writes, LONG_STALL, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rabs_pkg.sv
design/rabs_lane.sv
design/rabs_merge.sv
design/rabs_fifo.sv
design/running_average_background_subtract.sv
tb/tb_running_average_background_subtract.sv
